// ----- sv/assert_macros.svh -----
// Assertion macros shared by the chebyshev moment engine RTL.
// Each macro expects signals named clk and rst_n in the scope that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that holds on every rising clock edge outside reset.
`define CME_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// An implication checked on every rising clock edge outside reset.
`define CME_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ----- sv/cme_pkg.sv -----
// Package of the chebyshev moment engine: sizes, payload structs, state codes
// and saturation helpers. It depends on nothing else.
`default_nettype none

package cme_pkg;

  localparam int MAX_SITES        = 1024;
  localparam int MAX_MOMENT_PAIRS = 32;
  localparam int ADDR_W           = $clog2(MAX_SITES);
  localparam int CNT_W            = $clog2(MAX_SITES + 1);
  localparam int PAIR_W           = $clog2(MAX_MOMENT_PAIRS + 1);
  localparam int ACC_W            = 34 + $clog2(MAX_SITES);
  localparam int ONE_Q2_29        = 536870912;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_HOPPING = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF    = 2'd1;

  localparam logic signed [15:0] HOPPING_RESET = -16'sd13107;
  localparam logic [5:0]         HALF_RESET    = 6'd32;

  typedef struct packed {
    logic signed [15:0] elem_re;
    logic signed [15:0] elem_im;
    logic               last_element;
  } in_item_t;

  typedef struct packed {
    logic [5:0]         moment_index;
    logic signed [31:0] moment_value;
    logic               last_moment;
  } out_item_t;

  // Stored vector entry: real part in the low half.
  typedef struct packed {
    logic signed [15:0] im;
    logic signed [15:0] re;
  } cvec_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PASS,
    ST_DRAIN,
    ST_EMIT_EVEN,
    ST_EMIT_ODD
  } cme_state_t;

  function automatic logic signed [15:0] sat16(input logic signed [34:0] x);
    logic [19:0] hi;
    hi = x[34:15];
    if ((&hi) || !(|hi)) begin
      return x[15:0];
    end
    return x[34] ? 16'sh8000 : 16'sh7fff;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] x);
    logic [ACC_W-32:0] hi;
    hi = x[ACC_W-1:31];
    if ((&hi) || !(|hi)) begin
      return x[31:0];
    end
    return x[ACC_W-1] ? 32'sh80000000 : 32'sh7fffffff;
  endfunction

endpackage

`default_nettype wire

// ----- sv/cme_ram.sv -----
// Simple dual-port RAM with one write port and one registered read port.
// Generic; used by the chebyshev moment engine for its two vector stores.
`default_nettype none

module cme_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- sv/chebyshev_moment_engine.sv -----
// Chebyshev moment engine: stores a start vector one site per cycle while
// idle, then runs pairs passes over the stored sites, reading them through the
// single read port of each vector RAM, and emits a moment pair after each pass.
// Synchronous active-low reset clears control state; the RAMs are not cleared.
`default_nettype none

`include "assert_macros.svh"

module chebyshev_moment_engine (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire cme_pkg::in_item_t                   in_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output cme_pkg::out_item_t                       out_data,
  input  wire logic                                cfg_we,
  input  wire logic [cme_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [cme_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int AW  = cme_pkg::ADDR_W;
  localparam int CW  = cme_pkg::CNT_W;
  localparam int PW  = cme_pkg::PAIR_W;
  localparam int ACW = cme_pkg::ACC_W;

  cme_pkg::cme_state_t state_r, state_nxt;

  logic signed [15:0] hop_r;
  logic [5:0]         half_r;
  logic [CW-1:0]      site_cnt_r, n_r, j_r;
  logic [PW-1:0]      pairs_r, pass_r;
  logic               cur_b_r;
  logic signed [31:0] first_mom_r;

  logic               out_valid_r;
  cme_pkg::out_item_t out_data_r;

  logic in_acc, out_load, start_pass, site_full, pass0, last_pass;
  logic pipe_empty;

  // RAM ports
  logic          we_a, we_b;
  logic [AW-1:0] waddr_a, raddr_a, raddr_b, cur_addr, prev_addr;
  cme_pkg::cvec_t wdata_a, rd_a, rd_b;

  // pipeline
  logic           s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic [CW-1:0]  s1_j_r;
  cme_pkg::cvec_t win_l_r, win_m_r;
  cme_pkg::cvec_t cur_d, prev_d, right_d;
  logic           elem_v;
  logic signed [16:0] sum_re, sum_im;
  logic signed [32:0] prod_re, prod_im;
  logic signed [32:0] s2_prod_re_r, s2_prod_im_r;
  cme_pkg::cvec_t s2_prev_r, s2_mid_r, s3_new_r, s3_mid_r, new_v;
  logic [AW-1:0]  s2_idx_r;
  logic signed [33:0] pe_re, pe_im, rv_re, rv_im;
  logic signed [34:0] dv_re, dv_im;
  logic signed [31:0] s4_ss_re_r, s4_ss_im_r, s4_cr_re_r, s4_cr_im_r;
  logic signed [ACW-1:0] self_acc_r, cross_acc_r;
  logic signed [31:0] mu_even, mu_odd;

  assign in_ready  = (state_r == cme_pkg::ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_load  = !out_valid_r || out_ready;
  assign site_full = (site_cnt_r == CW'(cme_pkg::MAX_SITES));
  assign pass0     = (pass_r == '0);
  assign last_pass = (pass_r == PW'(pairs_r - 1'b1));
  assign pipe_empty = !(s1_v_r || s2_v_r || s3_v_r || s4_v_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cme_pkg::ST_IDLE: begin
        if (in_acc && in_data.last_element) begin
          state_nxt = cme_pkg::ST_PASS;
        end
      end
      cme_pkg::ST_PASS: begin
        if (j_r == n_r) begin
          state_nxt = cme_pkg::ST_DRAIN;
        end
      end
      cme_pkg::ST_DRAIN: begin
        if (pipe_empty) begin
          state_nxt = cme_pkg::ST_EMIT_EVEN;
        end
      end
      cme_pkg::ST_EMIT_EVEN: begin
        if (out_load) begin
          state_nxt = cme_pkg::ST_EMIT_ODD;
        end
      end
      cme_pkg::ST_EMIT_ODD: begin
        if (out_load) begin
          state_nxt = last_pass ? cme_pkg::ST_IDLE : cme_pkg::ST_PASS;
        end
      end
      default: state_nxt = cme_pkg::ST_IDLE;
    endcase
  end

  assign start_pass = (state_nxt == cme_pkg::ST_PASS) && (state_r != cme_pkg::ST_PASS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cme_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration and run control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hop_r       <= cme_pkg::HOPPING_RESET;
      half_r      <= cme_pkg::HALF_RESET;
      site_cnt_r  <= '0;
      n_r         <= '0;
      pairs_r     <= PW'(1);
      pass_r      <= '0;
      cur_b_r     <= 1'b0;
      j_r         <= '0;
      first_mom_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          cme_pkg::CFG_HOPPING: hop_r  <= cfg_data[15:0];
          cme_pkg::CFG_HALF:    half_r <= cfg_data[5:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        if (in_data.last_element) begin
          site_cnt_r <= '0;
          n_r        <= site_full ? site_cnt_r : site_cnt_r + 1'b1;
          pass_r     <= '0;
          cur_b_r    <= 1'b0;
          if (half_r == 6'd0) begin
            pairs_r <= PW'(1);
          end else if (int'(half_r) > cme_pkg::MAX_MOMENT_PAIRS) begin
            pairs_r <= PW'(cme_pkg::MAX_MOMENT_PAIRS);
          end else begin
            pairs_r <= PW'(half_r);
          end
        end else if (!site_full) begin
          site_cnt_r <= site_cnt_r + 1'b1;
        end
      end
      if (state_r == cme_pkg::ST_EMIT_ODD && out_load) begin
        if (pass0) begin
          first_mom_r <= mu_odd;
        end
        if (!last_pass) begin
          pass_r  <= pass_r + 1'b1;
          cur_b_r <= !cur_b_r;
        end
      end
      if (start_pass) begin
        j_r <= '0;
      end else if (state_r == cme_pkg::ST_PASS) begin
        j_r <= j_r + 1'b1;
      end
    end
  end

  // The current vector is read at j and the previous one at j - 1, so the previous
  // entry of element j - 1 arrives together with the current entry of element j.
  assign cur_addr  = j_r[AW-1:0];
  assign prev_addr = AW'(j_r - 1'b1);
  assign raddr_a   = cur_b_r ? prev_addr : cur_addr;
  assign raddr_b   = cur_b_r ? cur_addr : prev_addr;

  assign we_a    = (in_acc && !site_full) || (s2_v_r && cur_b_r);
  assign waddr_a = s2_v_r ? s2_idx_r : site_cnt_r[AW-1:0];
  assign wdata_a = s2_v_r ? new_v : cme_pkg::cvec_t'({in_data.elem_im, in_data.elem_re});
  assign we_b    = s2_v_r && !cur_b_r;

  cme_ram #(.DEPTH(cme_pkg::MAX_SITES), .WIDTH(32)) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr_a),
    .wdata (wdata_a),
    .raddr (raddr_a),
    .rdata (rd_a)
  );

  cme_ram #(.DEPTH(cme_pkg::MAX_SITES), .WIDTH(32)) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (s2_idx_r),
    .wdata (new_v),
    .raddr (raddr_b),
    .rdata (rd_b)
  );

  // Stage 1: neighbour sum and hopping product.
  always_comb begin
    cur_d   = cur_b_r ? rd_b : rd_a;
    prev_d  = cur_b_r ? rd_a : rd_b;
    right_d = (s1_j_r == n_r) ? '0 : cur_d;
    elem_v  = s1_v_r && (s1_j_r != '0);
    sum_re  = {win_l_r.re[15], win_l_r.re} + {right_d.re[15], right_d.re};
    sum_im  = {win_l_r.im[15], win_l_r.im} + {right_d.im[15], right_d.im};
    prod_re = hop_r * sum_re;
    prod_im = hop_r * sum_im;
  end

  // Stage 2: rounding, subtraction of the older vector after the first pass, saturation.
  always_comb begin
    pe_re = {s2_prod_re_r[32], s2_prod_re_r};
    pe_im = {s2_prod_im_r[32], s2_prod_im_r};
    if (pass0) begin
      rv_re = (pe_re + 34'sd16384) >>> 15;
      rv_im = (pe_im + 34'sd16384) >>> 15;
      dv_re = {rv_re[33], rv_re};
      dv_im = {rv_im[33], rv_im};
    end else begin
      rv_re = (pe_re + 34'sd8192) >>> 14;
      rv_im = (pe_im + 34'sd8192) >>> 14;
      dv_re = {rv_re[33], rv_re} - {{19{s2_prev_r.re[15]}}, s2_prev_r.re};
      dv_im = {rv_im[33], rv_im} - {{19{s2_prev_r.im[15]}}, s2_prev_r.im};
    end
    new_v.re = cme_pkg::sat16(dv_re);
    new_v.im = cme_pkg::sat16(dv_im);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      s1_v_r <= (state_r == cme_pkg::ST_PASS);
      s2_v_r <= elem_v;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_j_r <= j_r;
    if (start_pass) begin
      win_l_r <= '0;
      win_m_r <= '0;
    end else if (s1_v_r) begin
      win_l_r <= win_m_r;
      win_m_r <= right_d;
    end
    s2_prod_re_r <= prod_re;
    s2_prod_im_r <= prod_im;
    s2_prev_r    <= prev_d;
    s2_mid_r     <= win_m_r;
    s2_idx_r     <= AW'(s1_j_r - 1'b1);
    s3_new_r     <= new_v;
    s3_mid_r     <= s2_mid_r;
    s4_ss_re_r   <= s3_mid_r.re * s3_mid_r.re;
    s4_ss_im_r   <= s3_mid_r.im * s3_mid_r.im;
    s4_cr_re_r   <= s3_new_r.re * s3_mid_r.re;
    s4_cr_im_r   <= s3_new_r.im * s3_mid_r.im;
    if (start_pass) begin
      self_acc_r  <= '0;
      cross_acc_r <= '0;
    end else if (s4_v_r) begin
      self_acc_r  <= self_acc_r + ACW'(s4_ss_re_r) + ACW'(s4_ss_im_r);
      cross_acc_r <= cross_acc_r + ACW'(s4_cr_re_r) + ACW'(s4_cr_im_r);
    end
  end

  // Moment values of the pair that the finished pass gives.
  always_comb begin
    if (pass0) begin
      mu_even = 32'(cme_pkg::ONE_Q2_29);
      mu_odd  = cme_pkg::sat32((cross_acc_r + ACW'(1)) >>> 1);
    end else begin
      mu_even = cme_pkg::sat32(self_acc_r - ACW'(cme_pkg::ONE_Q2_29));
      mu_odd  = cme_pkg::sat32(cross_acc_r - ACW'(first_mom_r));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == cme_pkg::ST_EMIT_EVEN || state_r == cme_pkg::ST_EMIT_ODD) begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state_r == cme_pkg::ST_EMIT_EVEN) begin
        out_data_r.moment_index <= 6'({pass_r, 1'b0});
        out_data_r.moment_value <= mu_even;
        out_data_r.last_moment  <= 1'b0;
      end else if (state_r == cme_pkg::ST_EMIT_ODD) begin
        out_data_r.moment_index <= 6'({pass_r, 1'b1});
        out_data_r.moment_value <= mu_odd;
        out_data_r.last_moment  <= last_pass;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `CME_ASSERT_IMP(a_issue_bound, state_r == cme_pkg::ST_PASS, j_r <= n_r, "read issue past last site")
  `CME_ASSERT_IMP(a_emit_drained, state_r == cme_pkg::ST_EMIT_EVEN || state_r == cme_pkg::ST_EMIT_ODD, pipe_empty, "moment emitted before pass drained")
  `CME_ASSERT_IMP(a_pipe_order, s3_v_r, $past(s2_v_r), "pipeline valid out of step")
  `CME_ASSERT(a_no_load_in_pass, !(s2_v_r && in_acc), "start vector request during a pass")

endmodule

`default_nettype wire

// ----- test/tb_chebyshev_moment_engine.sv -----
// Testbench of the chebyshev moment engine: streams start vectors, predicts
// every Chebyshev moment in its own fixed-point model and checks each one.
// Depends on cme_pkg and chebyshev_moment_engine.
`default_nettype none

module tb_chebyshev_moment_engine;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [cme_pkg::CFG_IDX_W-1:0] CFG_NONE = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  cme_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  cme_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [cme_pkg::CFG_IDX_W-1:0] cfg_index = cme_pkg::CFG_HOPPING;
  logic [cme_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  chebyshev_moment_engine dut (.*);

  // Predictor state.
  logic signed [15:0] hop;
  int unsigned half_cfg;
  logic signed [15:0] old_re[cme_pkg::MAX_SITES], old_im[cme_pkg::MAX_SITES];
  logic signed [15:0] new_re[cme_pkg::MAX_SITES], new_im[cme_pkg::MAX_SITES];
  int unsigned sites;
  longint mu1;

  cme_pkg::in_item_t pending_items[$];
  cme_pkg::out_item_t moments_due[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 1'b0;
  bit hold_req = 1'b0;
  bit in_fire = 1'b0;

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("Mismatches found");
    $finish;
  end

  // The receiver hold-off is raised once requested and later lifted by itself.
  initial begin
    wait (hold_req);
    hold_off = 1'b1;
    repeat (400) @(posedge clk);
    hold_off = 1'b0;
  end

  function automatic longint sat_to32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic logic signed [15:0] sat_to16(longint x);
    if (x > 32767) return 16'sh7fff;
    if (x < -32768) return 16'sh8000;
    return x[15:0];
  endfunction

  // Adding half and then an arithmetic shift, which floors, rounds half up as the engine does.
  function automatic longint rnd_shift(longint x, int s);
    return (x + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint neighbour_sum(bit use_new, bit imag, int i, int n);
    longint s;
    s = 0;
    if (i > 0) s += use_new ? (imag ? new_im[i-1] : new_re[i-1])
                            : (imag ? old_im[i-1] : old_re[i-1]);
    if (i + 1 < n) s += use_new ? (imag ? new_im[i+1] : new_re[i+1])
                                : (imag ? old_im[i+1] : old_re[i+1]);
    return longint'(hop) * s;
  endfunction

  function automatic longint overlap(bit both_new, int n);
    longint acc;
    acc = 0;
    for (int i = 0; i < n; i++) begin
      if (both_new) acc += longint'(new_re[i]) * new_re[i] + longint'(new_im[i]) * new_im[i];
      else acc += longint'(new_re[i]) * old_re[i] + longint'(new_im[i]) * old_im[i];
    end
    return acc;
  endfunction

  function automatic void push_moment(int k, longint v, int total);
    cme_pkg::out_item_t m;
    m.moment_index = k[5:0];
    m.moment_value = v[31:0];
    m.last_moment = (k == total - 1);
    moments_due.insert(moments_due.size(), m);
  endfunction

  function automatic void predict_request(cme_pkg::in_item_t it);
    int n, pairs, k;
    logic signed [15:0] tr, ti;
    if (sites < cme_pkg::MAX_SITES) begin
      old_re[sites] = it.elem_re;
      old_im[sites] = it.elem_im;
      sites++;
    end
    if (!it.last_element) return;
    n = sites;
    sites = 0;
    pairs = half_cfg < 1 ? 1 : (half_cfg > cme_pkg::MAX_MOMENT_PAIRS ?
                                cme_pkg::MAX_MOMENT_PAIRS : half_cfg);
    for (int i = 0; i < n; i++) begin
      new_re[i] = sat_to16(rnd_shift(neighbour_sum(0, 0, i, n), 15));
      new_im[i] = sat_to16(rnd_shift(neighbour_sum(0, 1, i, n), 15));
    end
    mu1 = sat_to32(rnd_shift(overlap(0, n), 1));
    k = 0;
    push_moment(k, cme_pkg::ONE_Q2_29, 2 * pairs);
    k++;
    push_moment(k, mu1, 2 * pairs);
    k++;
    for (int p = 1; p < pairs; p++) begin
      push_moment(k, sat_to32(overlap(1, n) - cme_pkg::ONE_Q2_29), 2 * pairs);
      k++;
      // The older vector takes 2 H r(n) - r(n-1) in place, then the two swap.
      for (int i = 0; i < n; i++) begin
        old_re[i] = sat_to16(rnd_shift(neighbour_sum(1, 0, i, n), 14) - old_re[i]);
        old_im[i] = sat_to16(rnd_shift(neighbour_sum(1, 1, i, n), 14) - old_im[i]);
      end
      for (int i = 0; i < n; i++) begin
        tr = old_re[i];
        ti = old_im[i];
        old_re[i] = new_re[i];
        old_im[i] = new_im[i];
        new_re[i] = tr;
        new_im[i] = ti;
      end
      push_moment(k, sat_to32(overlap(0, n) - mu1), 2 * pairs);
      k++;
    end
  endfunction

  // Driver: a request is predicted when it is accepted.
  always @(posedge clk) begin
    in_fire = rst_n && in_valid && in_ready;
    if (in_fire) predict_request(in_data);
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_fire) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor.
  always @(posedge clk) begin
    cme_pkg::out_item_t exp_m;
    if (rst_n && out_valid && out_ready) begin
      if (moments_due.size() == 0) begin
        $display("%0t: unexpected moment %p", $realtime, out_data);
        errors++;
      end else begin
        exp_m = moments_due.pop_front();
        if (out_data.moment_index !== exp_m.moment_index ||
            out_data.moment_value !== exp_m.moment_value ||
            out_data.last_moment !== exp_m.last_moment) begin
          $display("%0t: expected %p, actual %p", $realtime, exp_m, out_data);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(logic [cme_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == cme_pkg::CFG_HOPPING) hop = val;
    else if (idx == cme_pkg::CFG_HALF) half_cfg = val[5:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic settle(int cycles);
    while (pending_items.size() > 0 || in_valid || moments_due.size() > 0) @(posedge clk);
    repeat (cycles) @(posedge clk);
  endtask

  task automatic add_vector(int n, bit extreme);
    cme_pkg::in_item_t it;
    for (int i = 0; i < n; i++) begin
      it.elem_re = extreme ? ($urandom_range(1) ? 16'sh7fff : 16'sh8000) : 16'($urandom);
      it.elem_im = extreme ? ($urandom_range(1) ? 16'sh7fff : 16'sh8000) : 16'($urandom);
      // Modest magnitudes keep most moments away from saturation.
      if (!extreme && $urandom_range(3) != 0) begin
        it.elem_re = it.elem_re >>> 4;
        it.elem_im = it.elem_im >>> 4;
      end
      it.last_element = (i == n - 1);
      pending_items.insert(pending_items.size(), it);
    end
  endtask

  int sent;

  initial begin
    hop = cme_pkg::HOPPING_RESET;
    half_cfg = cme_pkg::HALF_RESET;
    sites = 0;
    mu1 = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset settings, single site, extremes, pair count limits.
    add_vector(1, 0);
    add_vector(3, 1);
    settle(50);
    write_reg(cme_pkg::CFG_HALF, 16'd0);
    write_reg(cme_pkg::CFG_HOPPING, 16'h7fff);
    add_vector(4, 1);
    settle(50);
    write_reg(cme_pkg::CFG_HALF, 16'd63);
    write_reg(cme_pkg::CFG_HOPPING, 16'h8000);
    add_vector(2, 1);
    settle(50);
    write_reg(cme_pkg::CFG_HALF, 16'd1);
    write_reg(CFG_NONE, 16'hffff);
    add_vector(5, 0);
    settle(50);

    sent = 0;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 51; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 51; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      write_reg(cme_pkg::CFG_HOPPING,
                ph == 7 ? 16'h7fff : 16'($urandom_range(0, 32767) - 16384));
      write_reg(cme_pkg::CFG_HALF, 16'($urandom_range(0, 40)));
      while (sent < 45 * (ph + 1)) begin
        int n;
        n = $urandom_range(1, 12);
        add_vector(n, $urandom_range(9) == 0);
        sent += n;
      end
      if (ph == 2) begin
        // Hold the receiver back while vectors keep arriving.
        hold_req = 1'b1;
      end
      settle(50);
    end

    settle(100);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+sv
sv/cme_pkg.sv
sv/cme_ram.sv
sv/chebyshev_moment_engine.sv
test/tb_chebyshev_moment_engine.sv
